>>> src/pwfm_pkg.sv
package pwfm_pkg;

  // Default sizes of the pattern table
  localparam int unsigned PATTERNS_DEF      = 64;
  localparam int unsigned PATTERN_BYTES_DEF = 128;

  // Beat and configuration field widths
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;

  // Characters with a meaning to the matcher
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

  // Per-pattern matcher status
  typedef enum logic [1:0] {
    ST_CMP  = 2'd0,
    ST_SKIP = 2'd1,
    ST_HIT  = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // Decision of the compare unit for one step of one pattern
  typedef struct packed {
    logic    done;
    logic    adv;
    status_e status;
  } step_t;

endpackage

>>> src/pwfm_in_if.sv
interface pwfm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pwfm_pkg::IDX_W-1:0]  pattern_index;
  logic [pwfm_pkg::POS_W-1:0]  byte_position;
  logic [pwfm_pkg::CHAR_W-1:0] char_byte;
  logic                        last;

  modport source (
    output valid, mode, pattern_index, byte_position, char_byte, last,
    input  ready
  );
  modport sink (
    input  valid, mode, pattern_index, byte_position, char_byte, last,
    output ready
  );
endinterface

>>> src/pwfm_out_if.sv
interface pwfm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [pwfm_pkg::IDX_W-1:0] match_index;

  modport source (
    output valid, matched, match_index,
    input  ready
  );
  modport sink (
    input  valid, matched, match_index,
    output ready
  );
endinterface

>>> src/pwfm_cfg_if.sv
interface pwfm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pwfm_pkg::COUNT_W-1:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

>>> src/pwfm_ram.sv
module pwfm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pwfm_step.sv
module pwfm_step (
  input  pwfm_pkg::status_e           status_i,
  input  logic                        scan_i,
  input  logic [pwfm_pkg::CHAR_W-1:0] pat_char_i,
  input  logic [pwfm_pkg::CHAR_W-1:0] path_char_i,
  output pwfm_pkg::step_t             step_o
);

  // Byte above space that is not a separator
  function automatic logic seg_char(input logic [pwfm_pkg::CHAR_W-1:0] ch);
    return (ch > pwfm_pkg::CH_SPACE) && (ch != pwfm_pkg::CH_SLASH);
  endfunction

  // Plain byte compare; advance on an equal nonzero byte
  function automatic pwfm_pkg::step_t compare(input logic [pwfm_pkg::CHAR_W-1:0] pc,
                                              input logic [pwfm_pkg::CHAR_W-1:0] c);
    pwfm_pkg::step_t r;
    r.done = 1'b1;
    r.adv  = 1'b0;
    if (pc != c) begin
      r.status = (pc == pwfm_pkg::CH_NUL) ? pwfm_pkg::ST_HIT : pwfm_pkg::ST_MISS;
    end else if (pc == pwfm_pkg::CH_NUL) begin
      r.status = pwfm_pkg::ST_HIT;
    end else begin
      r.status = pwfm_pkg::ST_CMP;
      r.adv    = 1'b1;
    end
    return r;
  endfunction

  // Wildcard holds while the path stays inside the segment
  function automatic pwfm_pkg::step_t skip_res(input logic [pwfm_pkg::CHAR_W-1:0] pc,
                                               input logic [pwfm_pkg::CHAR_W-1:0] c);
    pwfm_pkg::step_t r;
    if (seg_char(c)) begin
      r = '{done: 1'b1, adv: 1'b0, status: pwfm_pkg::ST_SKIP};
    end else begin
      r = compare(pc, c);
    end
    return r;
  endfunction

  always_comb begin
    if (scan_i) begin
      // walking the pattern past the wildcard segment
      if (seg_char(pat_char_i)) begin
        step_o = '{done: 1'b0, adv: 1'b1, status: pwfm_pkg::ST_SKIP};
      end else begin
        step_o = skip_res(pat_char_i, path_char_i);
      end
    end else begin
      case (status_i)
        pwfm_pkg::ST_CMP: begin
          if (pat_char_i <= pwfm_pkg::CH_SPACE) begin
            step_o = '{done: 1'b1, adv: 1'b0,
                       status: (pat_char_i == pwfm_pkg::CH_NUL) ? pwfm_pkg::ST_HIT
                                                                : pwfm_pkg::ST_MISS};
          end else if (pat_char_i != pwfm_pkg::CH_STAR) begin
            step_o = compare(pat_char_i, path_char_i);
          end else begin
            step_o = '{done: 1'b0, adv: 1'b1, status: pwfm_pkg::ST_SKIP};
          end
        end
        pwfm_pkg::ST_SKIP: begin
          step_o = skip_res(pat_char_i, path_char_i);
        end
        default: begin
          step_o = '{done: 1'b1, adv: 1'b0, status: status_i};
        end
      endcase
    end
  end

endmodule

>>> src/path_wildcard_filter_match_unit.sv
// Path wildcard filter. Pattern bytes are loaded with mode 0 beats (one per cycle,
// out-of-range loads are dropped); path bytes follow with mode 1 beats, and the beat
// with last set yields one result: the lowest matching pattern below pattern_count.
// After reset the pattern store is cleared to zero, one byte a cycle; no beat is
// taken meanwhile, configuration writes are. Each path byte walks every pattern
// through one shared compare unit: a pattern already decided is passed over in the
// fetch state, a pending one is fetched and then evaluated, and the evaluation
// repeats for each pattern byte that a '*' skips over. The last byte adds a
// second walk for the end of the path. The input is not ready during a walk.
module path_wildcard_filter_match_unit #(
  parameter int unsigned PATTERNS      = pwfm_pkg::PATTERNS_DEF,
  parameter int unsigned PATTERN_BYTES = pwfm_pkg::PATTERN_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pwfm_in_if.sink           in_i,
  pwfm_out_if.source        out_o,
  pwfm_cfg_if.sink          cfg_i
);

  localparam int unsigned PW  = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned BW  = $clog2(PATTERN_BYTES);
  localparam int unsigned CW  = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned SAW = PW + BW;
  localparam int unsigned SW  = CW + 2;
  localparam int unsigned PX  = (PW > pwfm_pkg::IDX_W) ? PW : pwfm_pkg::IDX_W;
  localparam int unsigned BX  = (BW > pwfm_pkg::POS_W) ? BW : pwfm_pkg::POS_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_EVAL,
    S_PASS,
    S_FINISH
  } state_e;

  state_e                         state_q, state_d;
  logic [SAW-1:0]                 clr_q, clr_d;
  logic [PW-1:0]                  p_q, p_d;
  logic [pwfm_pkg::CHAR_W-1:0]    c_q, c_d;
  logic                           last_q, last_d;
  logic                           pass2_q, pass2_d;
  logic [CW-1:0]                  cur_q, cur_d;
  pwfm_pkg::status_e              st_q, st_d;
  logic                           scan_q, scan_d;
  logic [PATTERNS-1:0]            valid_q, valid_d;
  logic                           found_q, found_d;
  logic [PW-1:0]                  hit_q, hit_d;
  logic [pwfm_pkg::COUNT_W-1:0]   count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_matched_q, out_matched_d;
  logic [pwfm_pkg::IDX_W-1:0]     out_index_q, out_index_d;

  logic                           in_accept;
  logic                           load_ok;
  logic [PX-1:0]                  pidx_x;
  logic [BX-1:0]                  bpos_x;
  logic                           store_we;
  logic [SAW-1:0]                 store_waddr;
  logic [pwfm_pkg::CHAR_W-1:0]    store_wdata;
  logic [pwfm_pkg::CHAR_W-1:0]    store_rdata;
  logic                           stat_we;
  logic [SW-1:0]                  stat_rdata;
  logic [CW-1:0]                  f_cur;
  pwfm_pkg::status_e              f_st;
  logic [pwfm_pkg::CHAR_W-1:0]    pc;
  pwfm_pkg::step_t                step;
  logic                           fin;
  pwfm_pkg::status_e              fin_st;

  // Handshakes
  assign in_accept   = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid       = out_valid_q;
  assign out_o.matched     = out_matched_q;
  assign out_o.match_index = out_index_q;

  // Load address and range check
  assign pidx_x  = PX'(in_i.pattern_index);
  assign bpos_x  = BX'(in_i.byte_position);
  assign load_ok = (32'(in_i.pattern_index) < PATTERNS) &&
                   (32'(in_i.byte_position) < PATTERN_BYTES);

  // Pattern byte store
  pwfm_ram #(
    .WIDTH (pwfm_pkg::CHAR_W),
    .DEPTH (1 << SAW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .raddr_i ({p_q, cur_d[BW-1:0]}),
    .rdata_o (store_rdata)
  );

  // Per-pattern cursor and status; a pattern without its valid bit is fresh
  pwfm_ram #(
    .WIDTH (SW),
    .DEPTH (PATTERNS)
  ) u_status (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (p_q),
    .wdata_i ({cur_d, step.status}),
    .raddr_i (p_d),
    .rdata_o (stat_rdata)
  );

  assign f_cur = valid_q[p_q] ? stat_rdata[SW-1:2] : '0;
  assign f_st  = valid_q[p_q] ? pwfm_pkg::status_e'(stat_rdata[1:0]) : pwfm_pkg::ST_CMP;

  // Bytes past the pattern end read as zero
  assign pc = (32'(cur_q) < PATTERN_BYTES) ? store_rdata : pwfm_pkg::CH_NUL;

  // Shared compare unit
  pwfm_step u_step (
    .status_i    (st_q),
    .scan_i      (scan_q),
    .pat_char_i  (pc),
    .path_char_i (c_q),
    .step_o      (step)
  );

  // Sequencer
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    p_d           = p_q;
    c_d           = c_q;
    last_d        = last_q;
    pass2_d       = pass2_q;
    cur_d         = cur_q;
    st_d          = st_q;
    scan_d        = scan_q;
    valid_d       = valid_q;
    found_d       = found_q;
    hit_d         = hit_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q;
    out_matched_d = out_matched_q;
    out_index_d   = out_index_q;
    store_we      = 1'b0;
    store_waddr   = {pidx_x[PW-1:0], bpos_x[BW-1:0]};
    store_wdata   = in_i.char_byte;
    stat_we       = 1'b0;
    fin           = 1'b0;
    fin_st        = pwfm_pkg::ST_MISS;

    if (cfg_i.valid && cfg_i.ready) begin
      count_d = cfg_i.data;
    end
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        store_we    = 1'b1;
        store_waddr = clr_q;
        store_wdata = pwfm_pkg::CH_NUL;
        clr_d       = clr_q + SAW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (!in_i.mode) begin
            store_we = load_ok;
          end else begin
            c_d     = in_i.char_byte;
            last_d  = in_i.last;
            pass2_d = 1'b0;
            p_d     = '0;
            state_d = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cur_d  = f_cur;
        st_d   = f_st;
        scan_d = 1'b0;
        if (f_st == pwfm_pkg::ST_HIT || f_st == pwfm_pkg::ST_MISS) begin
          fin    = 1'b1;
          fin_st = f_st;
        end else begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cur_d = cur_q + CW'(step.adv);
        if (step.done) begin
          stat_we          = 1'b1;
          valid_d[p_q]     = 1'b1;
          fin              = 1'b1;
          fin_st           = step.status;
        end else begin
          scan_d = 1'b1;
        end
      end
      S_PASS: begin
        p_d     = '0;
        state_d = S_FETCH;
      end
      S_FINISH: begin
        if (!out_valid_q) begin
          out_valid_d   = 1'b1;
          out_matched_d = found_q;
          out_index_d   = pwfm_pkg::IDX_W'(hit_q);
          valid_d       = '0;
          found_d       = 1'b0;
          hit_d         = '0;
          pass2_d       = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // One pattern decided for this byte: track the result, move on
    if (fin) begin
      if (pass2_q && !found_q && fin_st == pwfm_pkg::ST_HIT &&
          32'(p_q) < 32'(count_q)) begin
        found_d = 1'b1;
        hit_d   = p_q;
      end
      if (32'(p_q) == PATTERNS - 1) begin
        if (pass2_q) begin
          state_d = S_FINISH;
        end else if (last_q) begin
          pass2_d = 1'b1;
          c_d     = pwfm_pkg::CH_NUL;
          state_d = S_PASS;
        end else begin
          state_d = S_IDLE;
        end
      end else begin
        p_d     = p_q + PW'(1);
        state_d = S_FETCH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      p_q           <= '0;
      c_q           <= '0;
      last_q        <= 1'b0;
      pass2_q       <= 1'b0;
      cur_q         <= '0;
      st_q          <= pwfm_pkg::ST_CMP;
      scan_q        <= 1'b0;
      valid_q       <= '0;
      found_q       <= 1'b0;
      hit_q         <= '0;
      count_q       <= pwfm_pkg::COUNT_RESET;
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
      out_index_q   <= '0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      p_q           <= p_d;
      c_q           <= c_d;
      last_q        <= last_d;
      pass2_q       <= pass2_d;
      cur_q         <= cur_d;
      st_q          <= st_d;
      scan_q        <= scan_d;
      valid_q       <= valid_d;
      found_q       <= found_d;
      hit_q         <= hit_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      out_matched_q <= out_matched_d;
      out_index_q   <= out_index_d;
    end
  end

`ifndef SYNTHESIS
  // A result only appears after the end-of-path walk
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("result raised outside finish");

  // Cursor never runs past the pattern end
  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (32'(cur_q) <= PATTERN_BYTES))
    else $error("cursor beyond pattern length");

  // No match reported with a nonzero index
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_matched_q) |-> (out_index_q == '0))
    else $error("nonzero index without a match");

  // Store writes only while clearing or idle
  a_store_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == S_CLEAR || state_q == S_IDLE))
    else $error("store written during a walk");
`endif

endmodule
